### rtl/assert_macros.svh
// assertion macros shared by the phase selector rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition and consequence checked at the same clock edge
`define MPS_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// consequence checked at the clock edge after the condition
`define MPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

### rtl/mps_pkg.sv
// shared types and constants of the max pressure phase selector
package mps_pkg;

  localparam int PHASE_W = 8;
  localparam int PRESS_W = 16;
  localparam int COUNT_FIELD_W = 10;
  localparam int MASK_FIELD_W = 32;

  localparam logic [1:0] CMD_LOAD_PHASE = 2'd0;
  localparam logic [1:0] CMD_LOAD_COUNT = 2'd1;
  localparam logic [1:0] CMD_EVAL       = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PH_RD,
    ST_PH_LD,
    ST_LANES,
    ST_CMP,
    ST_DONE
  } eval_state_t;

  typedef struct packed {
    logic                      busy;
    logic                      done;
    logic [PHASE_W-1:0]        phase;
    logic signed [PRESS_W-1:0] pressure;
  } eval_status_t;

endpackage

### rtl/mps_mem.sv
// single-port-write, registered-read memory with per-entry valid bits
module mps_mem #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid;
  logic [WIDTH-1:0] rd_q;
  logic             rd_valid;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[raddr];
  end

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (we) begin
        valid[waddr] <= 1'b1;
      end
      rd_valid <= valid[raddr];
    end
  end

  assign rdata = rd_valid ? rd_q : '0;

endmodule

### rtl/mps_eval.sv
// evaluation sequencer: walks phase slots and lanes, keeps the best pressure
module mps_eval #(
  parameter int MAX_PHASES = 8,
  parameter int MAX_LANES  = 32,
  parameter int COUNT_BITS = 10
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [$clog2(MAX_PHASES+1)-1:0] used,
  input  logic take,
  output logic [(MAX_PHASES > 1 ? $clog2(MAX_PHASES) : 1)-1:0] ph_raddr,
  input  logic [mps_pkg::PHASE_W+2*(MAX_LANES < 32 ? MAX_LANES : 32)-1:0] ph_rdata,
  output logic [$clog2(MAX_LANES)-1:0] ln_raddr,
  input  logic [(COUNT_BITS < 10 ? COUNT_BITS : 10)-1:0] ln_rdata,
  output mps_pkg::eval_status_t status
);

  localparam int ML     = (MAX_LANES < 32) ? MAX_LANES : 32;
  localparam int CNT_W  = (COUNT_BITS < 10) ? COUNT_BITS : 10;
  localparam int ACC_W  = CNT_W + $clog2(ML) + 1;
  localparam int PH_CW  = $clog2(MAX_PHASES + 1);
  localparam int PH_AW  = (MAX_PHASES > 1) ? $clog2(MAX_PHASES) : 1;
  localparam int LN_AW  = $clog2(MAX_LANES);
  localparam int LN_CW  = $clog2(ML + 1);
  localparam int PE_W   = mps_pkg::PHASE_W + 2 * ML;

  mps_pkg::eval_state_t state, state_next;

  logic [PH_CW-1:0]                 slot, slot_next;
  logic [LN_CW-1:0]                 lane, lane_next;
  logic [ML-1:0]                    in_sh, in_sh_next;
  logic [ML-1:0]                    out_sh, out_sh_next;
  logic [mps_pkg::PHASE_W-1:0]      num, num_next;
  logic [mps_pkg::PHASE_W-1:0]      best_num, best_num_next;
  logic signed [ACC_W-1:0]          acc, acc_next;
  logic signed [ACC_W-1:0]          best, best_next;
  logic signed [ACC_W-1:0]          cnt_ext;

  assign cnt_ext = $signed(ACC_W'(ln_rdata));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mps_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    slot     <= slot_next;
    lane     <= lane_next;
    in_sh    <= in_sh_next;
    out_sh   <= out_sh_next;
    num      <= num_next;
    best_num <= best_num_next;
    acc      <= acc_next;
    best     <= best_next;
  end

  always_comb begin
    state_next    = state;
    slot_next     = slot;
    lane_next     = lane;
    in_sh_next    = in_sh;
    out_sh_next   = out_sh;
    num_next      = num;
    best_num_next = best_num;
    acc_next      = acc;
    best_next     = best;
    case (state)
      mps_pkg::ST_IDLE: begin
        if (start) begin
          slot_next     = '0;
          lane_next     = '0;
          best_next     = '0;
          best_num_next = '0;
          state_next    = (used == '0) ? mps_pkg::ST_DONE : mps_pkg::ST_PH_RD;
        end
      end
      mps_pkg::ST_PH_RD: begin
        state_next = mps_pkg::ST_PH_LD;
      end
      mps_pkg::ST_PH_LD: begin
        num_next    = ph_rdata[PE_W-1 -: mps_pkg::PHASE_W];
        in_sh_next  = ph_rdata[2*ML-1 -: ML];
        out_sh_next = ph_rdata[ML-1:0];
        acc_next    = '0;
        lane_next   = LN_CW'(1);
        state_next  = mps_pkg::ST_LANES;
      end
      mps_pkg::ST_LANES: begin
        // count data belongs to lane - 1; a lane in both masks cancels
        case ({in_sh[0], out_sh[0]})
          2'b10:   acc_next = acc + cnt_ext;
          2'b01:   acc_next = acc - cnt_ext;
          default: acc_next = acc;
        endcase
        in_sh_next  = in_sh >> 1;
        out_sh_next = out_sh >> 1;
        if (lane == LN_CW'(ML)) begin
          state_next = mps_pkg::ST_CMP;
        end else begin
          lane_next = lane + LN_CW'(1);
        end
      end
      mps_pkg::ST_CMP: begin
        // first slot always wins over the initial bound
        if (slot == '0 || acc > best) begin
          best_next     = acc;
          best_num_next = num;
        end
        slot_next  = slot + PH_CW'(1);
        lane_next  = '0;
        state_next = (slot_next == used) ? mps_pkg::ST_DONE : mps_pkg::ST_PH_RD;
      end
      mps_pkg::ST_DONE: begin
        if (take) begin
          state_next = mps_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mps_pkg::ST_IDLE;
      end
    endcase
  end

  assign ph_raddr = slot[PH_AW-1:0];
  assign ln_raddr = lane[LN_AW-1:0];

  assign status.busy     = (state != mps_pkg::ST_IDLE);
  assign status.done     = (state == mps_pkg::ST_DONE);
  assign status.phase    = best_num;
  assign status.pressure = mps_pkg::PRESS_W'(best);

endmodule

### rtl/max_pressure_phase_select_core.sv
// top level of the max pressure phase selector
// Command channel (cmd_valid / cmd_stall) carries one item per transfer:
//   load phase slot writes phase_number and both lane masks into a slot,
//   load lane count writes vehicle_count for lane_slot, evaluate starts a
//   search; loads to slots or lanes beyond the configured sizes are dropped.
// Result channel (res_valid / res_stall) carries one transfer per evaluate:
//   best_phase and best_pressure of the first slot with the highest pressure.
// Config channel (cfg_valid / cfg_ready) writes phases_in_use; it is ready
//   whenever no evaluation is running.
// Loads are taken back to back while no evaluate holds cmd_stall.
// An evaluate holds cmd_stall until its result enters the output register,
//   valid in the next cycle; each of the N slots in use takes a phase read,
//   a phase load, one lane count per cycle from the count memory port for
//   L = min(MAX_LANES, 32) lanes, and a compare.
// The result sits in an output register: loads are taken while it waits,
//   and a later evaluate finishes its walk and then holds until the
//   receiver drops res_stall.
// Reset clears phases_in_use, the result valid and the valid bits of both
//   memories, so all slots and lane counts read as zero until written.
`include "assert_macros.svh"

module max_pressure_phase_select_core #(
  parameter int MAX_PHASES = 8,
  parameter int MAX_LANES  = 32,
  parameter int COUNT_BITS = 10
) (
  input  logic                               clk,
  input  logic                               rst,
  // command channel
  input  logic                               cmd_valid,
  output logic                               cmd_stall,
  input  logic [1:0]                         command,
  input  logic [2:0]                         phase_slot,
  input  logic [mps_pkg::PHASE_W-1:0]        phase_number,
  input  logic [mps_pkg::MASK_FIELD_W-1:0]   incoming_lane_mask,
  input  logic [mps_pkg::MASK_FIELD_W-1:0]   outgoing_lane_mask,
  input  logic [4:0]                         lane_slot,
  input  logic [mps_pkg::COUNT_FIELD_W-1:0]  vehicle_count,
  // result channel
  output logic                               res_valid,
  input  logic                               res_stall,
  output logic [mps_pkg::PHASE_W-1:0]        best_phase,
  output logic signed [mps_pkg::PRESS_W-1:0] best_pressure,
  // config channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [3:0]                         cfg_data
);

  localparam int ML    = (MAX_LANES < 32) ? MAX_LANES : 32;
  localparam int CNT_W = (COUNT_BITS < 10) ? COUNT_BITS : 10;
  localparam int PH_CW = $clog2(MAX_PHASES + 1);
  localparam int PH_AW = (MAX_PHASES > 1) ? $clog2(MAX_PHASES) : 1;
  localparam int LN_AW = $clog2(MAX_LANES);
  localparam int PE_W  = mps_pkg::PHASE_W + 2 * ML;

  logic [3:0]           phases_in_use;
  logic [PH_CW-1:0]     used;
  logic                 cmd_xfer;
  logic                 ph_we;
  logic                 ln_we;
  logic                 start;
  logic                 take;
  logic [PH_AW-1:0]     ph_raddr;
  logic [PE_W-1:0]      ph_rdata;
  logic [LN_AW-1:0]     ln_raddr;
  logic [CNT_W-1:0]     ln_rdata;
  mps_pkg::eval_status_t status;

  // command transfer and its decode
  assign cmd_xfer  = cmd_valid && !cmd_stall;
  assign cmd_stall = status.busy;
  assign ph_we = cmd_xfer && (command == mps_pkg::CMD_LOAD_PHASE) &&
                 (32'(phase_slot) < MAX_PHASES);
  assign ln_we = cmd_xfer && (command == mps_pkg::CMD_LOAD_COUNT) &&
                 (32'(lane_slot) < MAX_LANES);
  assign start = cmd_xfer && (command == mps_pkg::CMD_EVAL);

  // config register, written only between evaluations
  assign cfg_ready = !status.busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      phases_in_use <= '0;
    end else if (cfg_valid && cfg_ready) begin
      phases_in_use <= cfg_data;
    end
  end

  // slots in use saturate at the table size
  assign used = (32'(phases_in_use) > MAX_PHASES) ? PH_CW'(MAX_PHASES)
                                                  : PH_CW'(phases_in_use);

  // phase table: number, incoming mask, outgoing mask; mask bits past the
  // walked lanes are not stored
  mps_mem #(
    .WIDTH (PE_W),
    .DEPTH (MAX_PHASES)
  ) u_phase_mem (
    .clk   (clk),
    .rst   (rst),
    .we    (ph_we),
    .waddr (PH_AW'(phase_slot)),
    .wdata ({phase_number, incoming_lane_mask[ML-1:0], outgoing_lane_mask[ML-1:0]}),
    .raddr (ph_raddr),
    .rdata (ph_rdata)
  );

  // lane vehicle counts, truncated to the count width
  mps_mem #(
    .WIDTH (CNT_W),
    .DEPTH (MAX_LANES)
  ) u_count_mem (
    .clk   (clk),
    .rst   (rst),
    .we    (ln_we),
    .waddr (LN_AW'(lane_slot)),
    .wdata (vehicle_count[CNT_W-1:0]),
    .raddr (ln_raddr),
    .rdata (ln_rdata)
  );

  mps_eval #(
    .MAX_PHASES (MAX_PHASES),
    .MAX_LANES  (MAX_LANES),
    .COUNT_BITS (COUNT_BITS)
  ) u_eval (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .used     (used),
    .take     (take),
    .ph_raddr (ph_raddr),
    .ph_rdata (ph_rdata),
    .ln_raddr (ln_raddr),
    .ln_rdata (ln_rdata),
    .status   (status)
  );

  // output register: loads when empty or when the waiting result transfers
  assign take = status.done && (!res_valid || !res_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (take) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best_phase    <= status.phase;
      best_pressure <= status.pressure;
    end
  end

  // an accepted evaluate blocks further commands until it completes
  `MPS_ASSERT_NEXT(a_eval_blocks, clk, rst, start, cmd_stall)
  // with no slots in use the result is all zero
  `MPS_ASSERT_NEXT(a_empty_zero, clk, rst, take && (used == '0),
    res_valid && (best_phase == '0) && (best_pressure == '0))
  // pressure stays inside what the lane counts can reach
  `MPS_ASSERT_SAME(a_press_range, clk, rst, res_valid,
    (best_pressure <= 16'sd32736) && (best_pressure >= -16'sd32736))

endmodule
